>>> hdl/bipt_pkg.sv
// Shared constants, opcodes and controller interface types for the buffer tracker.
package bipt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int FUNC_W      = 3;
    localparam int TOKEN_W     = 64;
    localparam int SIZE_W      = 40;
    localparam int PEND_W      = 8;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int ENTRY_W     = TOKEN_W + SIZE_W + PEND_W;

    localparam logic [FUNC_W-1:0] FUNC_IMPORT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUEUE    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUFFER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PENDING = 2'd2;

    localparam logic [SIZE_W-1:0] MAX_BUFFER_RST  = 40'd67108864;
    localparam logic [SIZE_W-1:0] MAX_TOTAL_RST   = 40'd1073741824;
    localparam logic [PEND_W-1:0] MAX_PENDING_RST = 8'd16;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic commit;
    } bipt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } bipt_sts_t;

endpackage

>>> hdl/bipt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bipt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bipt_ctrl.sv
// Sequencer for one operation: accept, scan the table, decide and post the result.
module bipt_ctrl import bipt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bipt_sts_t sts,
    output bipt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            // last entry compares here, straight out of the RAM
            ST_LAST:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // hold while the previous result is still waiting
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/bipt_dp.sv
// Datapath: configuration, entry table, key scan, operation checks and result register.
module bipt_dp import bipt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bipt_cmd_t              cmd,
    output bipt_sts_t              sts,
    input  logic [FUNC_W-1:0]      func,
    input  logic [TOKEN_W-1:0]     token,
    input  logic [SIZE_W-1:0]      size_bytes,
    input  logic                   cfg_wr,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SIZE_W-1:0]      cfg_data,
    input  logic                   m_tready,
    output logic                   out_valid,
    output logic                   accepted,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic [SIZE_W-1:0]      total_bytes,
    output logic [PEND_W-1:0]      pending_total
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // configuration
    logic [SIZE_W-1:0] max_buffer_reg;
    logic [SIZE_W-1:0] max_total_reg;
    logic [PEND_W-1:0] max_pending_reg;

    // operation under work
    logic [FUNC_W-1:0]  func_reg;
    logic [TOKEN_W-1:0] token_reg;
    logic [SIZE_W-1:0]  size_reg;

    // table state
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SIZE_W-1:0]        sum_bytes_reg;
    logic [SIZE_W-1:0]        sum_bytes_next;
    logic [PEND_W-1:0]        sum_pend_reg;
    logic [PEND_W-1:0]        sum_pend_next;

    // scan
    logic [IDX_W-1:0] scan_addr_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic             match_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [SIZE_W-1:0] match_size_reg;
    logic [PEND_W-1:0] match_pend_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // entry RAM
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [TOKEN_W-1:0] rd_key;
    logic [SIZE_W-1:0]  rd_size;
    logic [PEND_W-1:0]  rd_pend;

    // decision
    logic             ok;
    logic             fits_total;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    // result register
    logic                   out_valid_reg;
    logic                   accepted_reg;
    logic [COUNT_OUT_W-1:0] entry_count_reg;
    logic [SIZE_W-1:0]      total_bytes_reg;
    logic [PEND_W-1:0]      pending_total_reg;

    bipt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_rd),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[TOKEN_W-1:0];
    assign rd_size = ram_rdata[TOKEN_W+SIZE_W-1:TOKEN_W];
    assign rd_pend = ram_rdata[ENTRY_W-1:TOKEN_W+SIZE_W];

    assign sts.scan_last = (scan_addr_reg == LAST_IDX);
    assign sts.out_busy  = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_buffer_reg  <= MAX_BUFFER_RST;
            max_total_reg   <= MAX_TOTAL_RST;
            max_pending_reg <= MAX_PENDING_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_MAX_BUFFER:  max_buffer_reg  <= cfg_data;
                CFG_MAX_TOTAL:   max_total_reg   <= cfg_data;
                CFG_MAX_PENDING: max_pending_reg <= cfg_data[PEND_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            token_reg <= token;
            size_reg  <= size_bytes;
        end
        cmp_idx_reg <= scan_addr_reg;
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg   <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan_rd;
            if (cmd.load)
            begin
                scan_addr_reg   <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_addr_reg <= scan_addr_reg + IDX_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && (rd_key == token_reg))
                    begin
                        match_found_reg <= 1'b1;
                    end
                    if (!valid_reg[cmp_idx_reg])
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // keep the first hit and the lowest free slot
    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg && !cmd.load)
        begin
            if (valid_reg[cmp_idx_reg] && (rd_key == token_reg) && !match_found_reg)
            begin
                match_idx_reg  <= cmp_idx_reg;
                match_size_reg <= rd_size;
                match_pend_reg <= rd_pend;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    assign fits_total = (size_reg <= max_total_reg) &&
                        (sum_bytes_reg <= (max_total_reg - size_reg));

    always_comb
    begin
        ok             = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = free_idx_reg;
        ram_wdata      = {{PEND_W{1'b0}}, size_reg, token_reg};
        valid_next     = valid_reg;
        count_next     = count_reg;
        sum_bytes_next = sum_bytes_reg;
        sum_pend_next  = sum_pend_reg;
        unique case (func_reg)
            FUNC_IMPORT:
            begin
                ok = (token_reg != '0) && (size_reg != '0) &&
                     (size_reg <= max_buffer_reg) && fits_total &&
                     !match_found_reg && free_found_reg;
                if (ok)
                begin
                    ram_we                   = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                    sum_bytes_next           = sum_bytes_reg + size_reg;
                end
            end
            FUNC_RELEASE:
            begin
                ok = match_found_reg && (match_pend_reg == '0);
                if (ok)
                begin
                    valid_next[match_idx_reg] = 1'b0;
                    count_next                = count_reg - CNT_W'(1);
                    sum_bytes_next            = sum_bytes_reg - match_size_reg;
                end
            end
            FUNC_QUEUE:
            begin
                ok        = match_found_reg && (sum_pend_reg < max_pending_reg);
                ram_waddr = match_idx_reg;
                ram_wdata = {match_pend_reg + PEND_W'(1), match_size_reg, token_reg};
                if (ok)
                begin
                    ram_we        = 1'b1;
                    sum_pend_next = sum_pend_reg + PEND_W'(1);
                end
            end
            FUNC_COMPLETE:
            begin
                ok = match_found_reg && (match_pend_reg != '0) && (sum_pend_reg != '0);
                ram_waddr = match_idx_reg;
                ram_wdata = {match_pend_reg - PEND_W'(1), match_size_reg, token_reg};
                if (ok)
                begin
                    ram_we        = 1'b1;
                    sum_pend_next = sum_pend_reg - PEND_W'(1);
                end
            end
            FUNC_CLEAR:
            begin
                ok             = 1'b1;
                valid_next     = '0;
                count_next     = '0;
                sum_bytes_next = '0;
                sum_pend_next  = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        ram_we = ram_we && cmd.commit;
    end

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            sum_bytes_reg <= '0;
            sum_pend_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            sum_bytes_reg <= sum_bytes_next;
            sum_pend_reg  <= sum_pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            accepted_reg      <= ok;
            entry_count_reg   <= count_wide[COUNT_OUT_W-1:0];
            total_bytes_reg   <= sum_bytes_next;
            pending_total_reg <= sum_pend_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign entry_count   = entry_count_reg;
    assign total_bytes   = total_bytes_reg;
    assign pending_total = pending_total_reg;

endmodule

>>> hdl/buffer_import_present_tracker.sv
// A result is registered: after its input beat is taken, the key scan (ST_SCAN, ST_LAST) and
// the decide step (ST_DECIDE) run before the commit; a new beat is taken only in ST_IDLE. The key
// scan reads one entry per cycle through the single read port of the entry RAM.
// A waiting result does not block the next beat; only the commit step waits for m_tready.
// Reset (rst_n low, asynchronous) empties the table, zeroes both sums and restores the
// limit registers; entry contents stay undefined and need no clearing pass.
module buffer_import_present_tracker import bipt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [103:0]         s_tdata,   // token[63:0], size_bytes[103:64]
    input  logic [FUNC_W-1:0]    s_tuser,   // func[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // entry_count[4:0], total_bytes[44:5],
                                            // pending_total[52:45], zero[55:53]
    output logic [0:0]           m_tuser,   // accepted[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    bipt_cmd_t              cmd;
    bipt_sts_t              sts;
    logic                   accepted;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic [SIZE_W-1:0]      total_bytes;
    logic [PEND_W-1:0]      pending_total;

    assign cfg_ready = 1'b1;

    bipt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bipt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (s_tuser),
        .token         (s_tdata[TOKEN_W-1:0]),
        .size_bytes    (s_tdata[TOKEN_W+SIZE_W-1:TOKEN_W]),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .accepted      (accepted),
        .entry_count   (entry_count),
        .total_bytes   (total_bytes),
        .pending_total (pending_total)
    );

    assign m_tdata = {3'b000, pending_total, total_bytes, entry_count};
    assign m_tuser = accepted;

endmodule

>>> hdl/bipt_chk.sv
// Port-level checks for the buffer tracker, bound to the top level.
module bipt_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    logic       in_beat;
    logic       out_beat;
    logic [2:0] outstanding_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // count beats taken in and not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            outstanding_reg <= outstanding_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            outstanding_reg <= outstanding_reg - 3'd1;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input taken again right after a beat");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (outstanding_reg != 3'd0))
        else $error("result shown with no input outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd2)
        else $error("more than two items in flight");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind buffer_import_present_tracker bipt_chk u_bipt_chk (.*);

>>> verif/buffer_import_present_tracker_test.sv
// Self-checking testbench for the imported buffer / present tracker.
`timescale 1ns / 1ps

module buffer_import_present_tracker_test import bipt_pkg::*;;

    localparam int ENTRIES     = TABLE_ENTRIES_DEF;
    localparam int POOL        = 20;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 218;
    localparam int IDLE_PCT    = 22;

    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    localparam logic [TOKEN_W-1:0] TOKEN_ALL1 = {TOKEN_W{1'b1}};
    localparam logic [TOKEN_W-1:0] TOKEN_TOP  = 64'h8000_0000_0000_0000;
    localparam logic [TOKEN_W-1:0] TOKEN_MID  = 64'h0123_4567_89AB_CDEF;
    localparam logic [SIZE_W-1:0]  SIZE_ALL1  = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_MID   = 40'h00_0300_0000;
    localparam logic [SIZE_W-1:0]  BYTES_TWO  = MAX_BUFFER_RST + 40'd1;

    typedef struct packed {
        logic                   accepted;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [SIZE_W-1:0]      total_bytes;
        logic [PEND_W-1:0]      pending_total;
    } status_t;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [TOKEN_W-1:0] token;
        logic [SIZE_W-1:0]  size;
        bit                 typed;
        status_t            want;
    } op_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [103:0]         s_tdata = '0;
    logic [FUNC_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [55:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    buffer_import_present_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tracker state as the block should hold it
    bit                 tbl_valid [ENTRIES];
    logic [TOKEN_W-1:0] tbl_key   [ENTRIES];
    logic [SIZE_W-1:0]  tbl_size  [ENTRIES];
    logic [PEND_W-1:0]  tbl_pend  [ENTRIES];
    logic [SIZE_W-1:0]  used_bytes = '0;
    logic [PEND_W-1:0]  used_pend  = '0;
    logic [SIZE_W-1:0]  lim_buffer = MAX_BUFFER_RST;
    logic [SIZE_W-1:0]  lim_total  = MAX_TOTAL_RST;
    logic [PEND_W-1:0]  lim_pend   = MAX_PENDING_RST;

    status_t            status_due [$];
    op_row_t            op_rows [$];
    logic [TOKEN_W-1:0] token_pool [POOL];
    bit                 idle_on = 1'b1;
    int                 mismatches = 0;

    function automatic status_t track_op(input logic [FUNC_W-1:0] func,
                                         input logic [TOKEN_W-1:0] token,
                                         input logic [SIZE_W-1:0] size);
        status_t res;
        int      hit;
        int      slot;
        int      cnt;
        bit      ok;
        hit  = -1;
        slot = -1;
        cnt  = 0;
        ok   = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (tbl_valid[i] && tbl_key[i] == token)
                hit = i;
            if (!tbl_valid[i])
                slot = i;
        end
        case (func)
            FUNC_IMPORT:
            begin
                if (token != 0 && size != 0 && size <= lim_buffer && size <= lim_total &&
                    hit < 0 && used_bytes <= lim_total - size && slot >= 0)
                begin
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = token;
                    tbl_size[slot]  = size;
                    tbl_pend[slot]  = '0;
                    used_bytes      = used_bytes + size;
                    ok              = 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                if (hit >= 0 && tbl_pend[hit] == 0)
                begin
                    used_bytes     = used_bytes - tbl_size[hit];
                    tbl_valid[hit] = 1'b0;
                    ok             = 1'b1;
                end
            end
            FUNC_QUEUE:
            begin
                if (hit >= 0 && used_pend < lim_pend)
                begin
                    tbl_pend[hit] = tbl_pend[hit] + 1'b1;
                    used_pend     = used_pend + 1'b1;
                    ok            = 1'b1;
                end
            end
            FUNC_COMPLETE:
            begin
                if (hit >= 0 && tbl_pend[hit] != 0 && used_pend != 0)
                begin
                    tbl_pend[hit] = tbl_pend[hit] - 1'b1;
                    used_pend     = used_pend - 1'b1;
                    ok            = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
                used_bytes = '0;
                used_pend  = '0;
                ok         = 1'b1;
            end
            default:
                ok = 1'b0;
        endcase
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                cnt++;
        res.accepted      = ok;
        res.entry_count   = cnt[COUNT_OUT_W-1:0];
        res.total_bytes   = used_bytes;
        res.pending_total = used_pend;
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] rand40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[SIZE_W-1:0];
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] func, input logic [TOKEN_W-1:0] token,
                           input logic [SIZE_W-1:0] size, input bit typed,
                           input logic acc, input logic [COUNT_OUT_W-1:0] cnt,
                           input logic [SIZE_W-1:0] tot, input logic [PEND_W-1:0] pnd);
        op_row_t row;
        row.func  = func;
        row.token = token;
        row.size  = size;
        row.typed = typed;
        row.want  = '{acc, cnt, tot, pnd};
        op_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [TOKEN_W-1:0] token,
                           input logic [SIZE_W-1:0] size, input bit typed,
                           input status_t want);
        status_t predicted;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {size, token};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = track_op(func, token, size);
        status_due.push_back(typed ? want : predicted);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MAX_BUFFER:  lim_buffer = value;
            CFG_MAX_TOTAL:   lim_total  = value;
            CFG_MAX_PENDING: lim_pend   = value[PEND_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold until every result is back, then let the pipeline settle.
    task automatic drain();
        s_tvalid = 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_op(output logic [FUNC_W-1:0] func, output logic [TOKEN_W-1:0] token,
                             output logic [SIZE_W-1:0] size);
        int          k;
        logic [63:0] cap;
        logic [63:0] r;
        k = $urandom_range(0, 99);
        if (k < 32)
            func = FUNC_IMPORT;
        else if (k < 47)
            func = FUNC_RELEASE;
        else if (k < 70)
            func = FUNC_QUEUE;
        else if (k < 93)
            func = FUNC_COMPLETE;
        else if (k < 95)
            func = FUNC_CLEAR;
        else
        begin
            case ($urandom_range(0, 2))
                0:       func = FUNC_RSVD5;
                1:       func = FUNC_RSVD6;
                default: func = FUNC_RSVD7;
            endcase
        end

        k = $urandom_range(0, 99);
        if (k < 86)
            token = token_pool[$urandom_range(0, POOL - 1)];
        else if (k < 96)
            token = {$urandom, $urandom};
        else
            token = '0;

        k = $urandom_range(0, 99);
        if (k < 3)
            size = '0;
        else if (k < 9)
            size = lim_buffer;
        else if (k < 13)
            size = lim_buffer + 1'b1;
        else if (k < 19)
            size = rand40();
        else
        begin
            // keep most sizes small enough that several buffers fit in the total
            cap = 64'(lim_buffer);
            if ((lim_total >> 2) != 0 && (lim_total >> 2) < cap)
                cap = 64'(lim_total >> 2);
            r    = {$urandom, $urandom};
            r    = 64'd1 + (r % cap);
            size = r[SIZE_W-1:0];
        end
    endtask

    always @(negedge clk)
        m_tready = !(idle_on && $urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accepted      = m_tuser[0];
            got.entry_count   = m_tdata[4:0];
            got.total_bytes   = m_tdata[44:5];
            got.pending_total = m_tdata[52:45];
            if (status_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat: acc=%0d cnt=%0d bytes=%0d pend=%0d",
                             got.accepted, got.entry_count, got.total_bytes,
                             got.pending_total);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                if (got.accepted !== want.accepted || got.entry_count !== want.entry_count ||
                    got.total_bytes !== want.total_bytes ||
                    got.pending_total !== want.pending_total)
                begin
                    // fields shown as acc/cnt/bytes/pend
                    if (mismatches < 10)
                        $display("mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.accepted, want.entry_count, want.total_bytes,
                                 want.pending_total, got.accepted, got.entry_count,
                                 got.total_bytes, got.pending_total);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [FUNC_W-1:0]  func;
        logic [TOKEN_W-1:0] token;
        logic [SIZE_W-1:0]  size;
        logic [SIZE_W-1:0]  lim;
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        token_pool[0] = TOKEN_ALL1;
        token_pool[1] = 64'd1;
        token_pool[2] = TOKEN_TOP;
        for (int i = 3; i < POOL; i++)
        begin
            token_pool[i] = {$urandom, $urandom};
            if (token_pool[i] == 0)
                token_pool[i] = 64'd2;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: limits are at their reset values here.
        add_row(FUNC_IMPORT, 64'd0, 40'd100, 1'b1, 1'b0, 5'd0, 40'd0, 8'd0);
        add_row(FUNC_IMPORT, 64'd1, 40'd0, 1'b1, 1'b0, 5'd0, 40'd0, 8'd0);
        add_row(FUNC_IMPORT, 64'd1, SIZE_ALL1, 1'b1, 1'b0, 5'd0, 40'd0, 8'd0);
        add_row(FUNC_IMPORT, 64'd1, MAX_BUFFER_RST + 1'b1, 1'b1, 1'b0, 5'd0, 40'd0, 8'd0);
        add_row(FUNC_IMPORT, TOKEN_ALL1, MAX_BUFFER_RST, 1'b1, 1'b1, 5'd1, MAX_BUFFER_RST, 8'd0);
        add_row(FUNC_IMPORT, TOKEN_ALL1, 40'd5, 1'b1, 1'b0, 5'd1, MAX_BUFFER_RST, 8'd0);
        add_row(FUNC_IMPORT, TOKEN_TOP, 40'd1, 1'b1, 1'b1, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_RELEASE, 64'd5, 40'd0, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_QUEUE, TOKEN_ALL1, 40'd0, 1'b1, 1'b1, 5'd2, BYTES_TWO, 8'd1);
        add_row(FUNC_QUEUE, TOKEN_ALL1, 40'd0, 1'b1, 1'b1, 5'd2, BYTES_TWO, 8'd2);
        add_row(FUNC_RELEASE, TOKEN_ALL1, 40'd0, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd2);
        add_row(FUNC_COMPLETE, TOKEN_ALL1, 40'd0, 1'b1, 1'b1, 5'd2, BYTES_TWO, 8'd1);
        add_row(FUNC_COMPLETE, TOKEN_TOP, 40'd0, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd1);
        add_row(FUNC_QUEUE, 64'd3, 40'd0, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd1);
        add_row(FUNC_COMPLETE, TOKEN_ALL1, 40'd0, 1'b1, 1'b1, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_COMPLETE, TOKEN_ALL1, 40'd0, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_RSVD5, TOKEN_ALL1, 40'd1, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_RSVD6, TOKEN_TOP, SIZE_ALL1, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_RSVD7, 64'd0, 40'd0, 1'b1, 1'b0, 5'd2, BYTES_TWO, 8'd0);
        add_row(FUNC_RELEASE, TOKEN_ALL1, 40'd0, 1'b1, 1'b1, 5'd1, 40'd1, 8'd0);
        add_row(FUNC_QUEUE, TOKEN_TOP, 40'd0, 1'b1, 1'b1, 5'd1, 40'd1, 8'd1);
        add_row(FUNC_IMPORT, TOKEN_MID, SIZE_MID, 1'b0, 1'b0, 5'd0, 40'd0, 8'd0);
        add_row(FUNC_CLEAR, 64'd0, 40'd0, 1'b1, 1'b1, 5'd0, 40'd0, 8'd0);
        add_row(FUNC_RELEASE, TOKEN_TOP, 40'd0, 1'b1, 1'b0, 5'd0, 40'd0, 8'd0);
        foreach (op_rows[i])
            send_op(op_rows[i].func, op_rows[i].token, op_rows[i].size, op_rows[i].typed,
                    op_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1:
                    begin
                        write_cfg(CFG_MAX_BUFFER, SIZE_ALL1);
                        write_cfg(CFG_MAX_TOTAL, SIZE_ALL1);
                        write_cfg(CFG_MAX_PENDING, 40'd255);
                    end
                    2:
                    begin
                        write_cfg(CFG_MAX_BUFFER, 40'd1);
                        write_cfg(CFG_MAX_TOTAL, 40'd1);
                        write_cfg(CFG_MAX_PENDING, 40'd1);
                    end
                    3:
                    begin
                        write_cfg(CFG_MAX_BUFFER, 40'd1000);
                        write_cfg(CFG_MAX_TOTAL, 40'd4000);
                        write_cfg(CFG_MAX_PENDING, 40'd8);
                    end
                    4:
                    begin
                        // a zero pending limit refuses every queue
                        lim = rand40();
                        write_cfg(CFG_MAX_BUFFER, (lim == 0) ? 40'd1 : lim);
                        lim = rand40();
                        write_cfg(CFG_MAX_TOTAL, (lim == 0) ? 40'd1 : lim);
                        write_cfg(CFG_MAX_PENDING, 40'd0);
                    end
                    5:
                    begin
                        write_cfg(CFG_MAX_BUFFER, 40'($urandom_range(1, 5000)));
                        write_cfg(CFG_MAX_TOTAL, 40'($urandom_range(1, 20000)));
                        write_cfg(CFG_MAX_PENDING, 40'($urandom_range(1, 255)));
                    end
                    default:
                    begin
                        write_cfg(CFG_MAX_BUFFER, MAX_BUFFER_RST);
                        write_cfg(CFG_MAX_TOTAL, MAX_TOTAL_RST);
                        write_cfg(CFG_MAX_PENDING, 40'(MAX_PENDING_RST));
                    end
                endcase
            end
            // one phase runs with both sides at full rate
            idle_on = (p != 1);
            @(negedge clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_op(func, token, size);
                send_op(func, token, size, 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
